### src/hws_pkg.sv
// Shared constants, types and codes for the HRV window statistics block.
package hws_pkg;

  // Window depth in intervals; power of two so ring addresses wrap for free
  localparam int unsigned WinDepth = 64;
  localparam int unsigned AddrW    = $clog2(WinDepth);

  // Field and accumulator widths
  localparam int unsigned IbiW  = 18;
  localparam int unsigned CntW  = 7;
  localparam int unsigned SumW  = 24;
  localparam int unsigned SqW   = 42;
  localparam int unsigned SsdW  = 41;
  localparam int unsigned HrW   = 16;
  localparam int unsigned ProdW = 48;
  localparam int unsigned DivNW = 48;
  localparam int unsigned DivDW = 24;
  localparam int unsigned RootW = DivNW / 2;
  localparam int unsigned NnW   = 2 * CntW - 1;

  // Plausibility limit and heart-rate scaling
  localparam logic [IbiW-1:0] IbiMax     = IbiW'(160000);
  localparam logic [SumW-1:0] HrNumer    = SumW'(15360000);
  localparam logic [HrW-1:0]  HrSat      = '1;
  localparam logic [CntW-1:0] ThreshRst  = CntW'(2);

  // Decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  // One classified input transaction
  typedef struct packed {
    logic [IbiW-1:0] ibi;
    logic            ok;
  } hws_item_t;

  // Result word held in the output register
  typedef struct packed {
    logic            accepted;
    logic [CntW-1:0] count;
    logic            rdy;
    logic [IbiW-1:0] ibi_avg;
    logic [HrW-1:0]  mean_hr;
    logic [IbiW-1:0] sdnn;
    logic [IbiW-1:0] rmssd;
  } hws_res_t;

endpackage

### src/hws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hws_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/hws_front.sv
// Front end: takes input transactions and classifies each interval.
module hws_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hws_pkg::IbiW-1:0]  ibi_q4_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output hws_pkg::hws_item_t        q_item_o
);
  import hws_pkg::*;

  // Accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Plausible range is 1/16 .. 10000 ms
  always_comb begin
    q_item_o.ibi = ibi_q4_i;
    q_item_o.ok  = (ibi_q4_i != '0) && (ibi_q4_i <= IbiMax);
  end

endmodule

### src/hws_queue.sv
// Short queue of classified intervals between front and back.
module hws_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hws_pkg::hws_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hws_pkg::hws_item_t item_o
);
  import hws_pkg::*;

  hws_item_t        slot_q [QDepth];
  logic [QAw-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QAw:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rptr_q];

  // Pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

### src/hws_div.sv
// Restoring divider, one quotient bit per cycle.
module hws_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hws_pkg::DivNW-1:0] dividend_i,
  input  logic [hws_pkg::DivDW-1:0] divisor_i,
  output logic                      done_o,
  output logic [hws_pkg::DivNW-1:0] quot_o
);
  import hws_pkg::*;

  localparam int unsigned CW = $clog2(DivNW);

  logic [DivDW:0]   rem_q;
  logic [DivNW-1:0] quo_q;
  logic [DivDW-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DivDW:0]   trial;
  logic             ge;

  // One shift-and-subtract step
  assign trial = {rem_q[DivDW-1:0], quo_q[DivNW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DivNW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### src/hws_sqrt.sv
// Floor integer square root, one root bit per cycle.
module hws_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hws_pkg::DivNW-1:0] rad_i,
  output logic                      done_o,
  output logic [hws_pkg::RootW-1:0] root_o
);
  import hws_pkg::*;

  localparam int unsigned CW = $clog2(RootW);
  localparam int unsigned RW = RootW + 2;

  logic [DivNW-1:0] val_q;
  logic [RW-1:0]    rem_q;
  logic [RootW-1:0] root_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [RW:0]      rsh, trial;
  logic             ge;

  // Bring down two bits, try root*4+1
  assign rsh   = {rem_q[RW-2:0], val_q[DivNW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = (rsh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[DivNW-3:0], 2'b00};
      rem_q  <= ge ? RW'(rsh - trial) : RW'(rsh);
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/hws_back.sv
// Back end: window update, running sums, statistics and output register.
module hws_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  hws_pkg::hws_item_t        q_item_i,
  input  logic [hws_pkg::CntW-1:0]  thresh_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hws_pkg::hws_res_t         res_o
);
  import hws_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RD1  = 4'd2;
  localparam logic [3:0] ST_RD2  = 4'd3;
  localparam logic [3:0] ST_RD3  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_STAT = 4'd7;
  localparam logic [3:0] ST_P0   = 4'd8;
  localparam logic [3:0] ST_P1   = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_DIVW = 4'd11;
  localparam logic [3:0] ST_SQ   = 4'd12;
  localparam logic [3:0] ST_SQW  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  localparam logic [CntW-1:0] CntFull = CntW'(WinDepth);

  logic [3:0]       st_q;
  logic [1:0]       k_q;
  logic [AddrW-1:0] wi_q;
  logic [CntW-1:0]  cnt_q;
  logic [SumW-1:0]  sum_q;
  logic [SqW-1:0]   sq_q;
  logic [SsdW-1:0]  ssd_q;
  logic             out_valid_q;

  // Per-transaction working registers
  logic [IbiW-1:0]  ibi_q, old_q, nxt_q, prv_q;
  logic             ok_q, ev_q, hp_q;
  logic [ProdW-1:0] prod_q;
  logic [CntW+SqW-1:0] nq_q;
  logic [NnW-1:0]   nn_q;
  logic [DivNW-1:0] num_q, var_q, rdv_q;
  hws_res_t         res_q, wk_q;

  // Shared multiplier operands
  logic [SumW-1:0]  mul_a, mul_b;
  logic [IbiW-1:0]  dif_a, dif_b, dif;

  // RAM and iterative units
  logic             ram_we;
  logic [AddrW-1:0] ram_ra;
  logic [IbiW-1:0]  ram_rd;
  logic             div_start, div_done, sq_start, sq_done;
  logic [DivNW-1:0] div_n, div_quo, sq_rad;
  logic [DivDW-1:0] div_d;
  logic [RootW-1:0] sq_root;

  hws_ram #(.WIDTH(IbiW), .DEPTH(WinDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (ibi_q),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  hws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  hws_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Read addresses: oldest, the one after it, the newest
  always_comb begin
    case (st_q)
      ST_RD0:  ram_ra = wi_q;
      ST_RD1:  ram_ra = wi_q + 1'b1;
      default: ram_ra = wi_q - 1'b1;
    endcase
  end

  assign ram_we  = (st_q == ST_ACC) && (k_q == 2'd3);
  assign q_pop_o = (st_q == ST_IDLE) && !q_empty_i;

  // Multiplier operand select
  always_comb begin
    dif_a = (k_q[1]) ? ibi_q : nxt_q;
    dif_b = (k_q[1]) ? prv_q : old_q;
    dif   = (dif_a > dif_b) ? (dif_a - dif_b) : (dif_b - dif_a);
    mul_a = SumW'(old_q);
    mul_b = SumW'(old_q);
    case (st_q)
      ST_MUL: begin
        case (k_q)
          2'd0:    begin mul_a = SumW'(old_q); mul_b = SumW'(old_q); end
          2'd2:    begin mul_a = SumW'(ibi_q); mul_b = SumW'(ibi_q); end
          default: begin mul_a = SumW'(dif);   mul_b = SumW'(dif);   end
        endcase
      end
      ST_P0:   begin mul_a = sum_q;   mul_b = sum_q;         end
      default: begin mul_a = HrNumer; mul_b = SumW'(cnt_q);  end
    endcase
  end

  // Divider and root operand select
  always_comb begin
    case (k_q)
      2'd0: begin
        div_n = DivNW'(sum_q);
        div_d = DivDW'(cnt_q);
      end
      2'd1: begin
        div_n = prod_q;
        div_d = sum_q;
      end
      2'd2: begin
        div_n = num_q;
        div_d = DivDW'(nn_q);
      end
      default: begin
        div_n = DivNW'(ssd_q);
        div_d = DivDW'(cnt_q - 1'b1);
      end
    endcase
    sq_rad    = k_q[0] ? rdv_q : var_q;
    div_start = (st_q == ST_DIV);
    sq_start  = (st_q == ST_SQ);
  end

  // Sequencer and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      k_q         <= '0;
      wi_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      ssd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output register: load a new result or drop the one just taken
      if (st_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          k_q <= '0;
          if (!q_empty_i) begin
            st_q <= q_item_i.ok ? ST_RD0 : ST_STAT;
          end
        end
        ST_RD0: st_q <= ST_RD1;
        ST_RD1: st_q <= ST_RD2;
        ST_RD2: st_q <= ST_RD3;
        ST_RD3: st_q <= ST_MUL;
        ST_MUL: st_q <= ST_ACC;
        ST_ACC: begin
          k_q  <= k_q + 1'b1;
          st_q <= (k_q == 2'd3) ? ST_STAT : ST_MUL;
          case (k_q)
            2'd0: if (ev_q) sq_q  <= sq_q - SqW'(prod_q);
            2'd1: if (ev_q) ssd_q <= ssd_q - SsdW'(prod_q);
            2'd2: sq_q <= sq_q + SqW'(prod_q);
            default: begin
              if (hp_q) ssd_q <= ssd_q + SsdW'(prod_q);
              sum_q <= sum_q - (ev_q ? SumW'(old_q) : '0) + SumW'(ibi_q);
              if (!ev_q) cnt_q <= cnt_q + 1'b1;
              wi_q <= wi_q + 1'b1;
            end
          endcase
        end
        ST_STAT: begin
          k_q  <= '0;
          st_q <= (cnt_q < CntW'(2)) ? ST_OUT : ST_P0;
        end
        ST_P0: st_q <= ST_P1;
        ST_P1: st_q <= ST_DIV;
        ST_DIV: st_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            k_q  <= k_q + 1'b1;
            st_q <= (k_q == 2'd3) ? ST_SQ : ST_DIV;
          end
        end
        ST_SQ: st_q <= ST_SQW;
        ST_SQW: begin
          if (sq_done) begin
            k_q  <= k_q + 1'b1;
            st_q <= k_q[0] ? ST_OUT : ST_SQ;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        ibi_q <= q_item_i.ibi;
        ok_q  <= q_item_i.ok;
        ev_q  <= q_item_i.ok && (cnt_q == CntFull);
        hp_q  <= q_item_i.ok && (cnt_q != '0);
      end
      ST_RD1: old_q <= ram_rd;
      ST_RD2: nxt_q <= ram_rd;
      ST_RD3: prv_q <= ram_rd;
      ST_MUL: prod_q <= mul_a * mul_b;
      ST_STAT: begin
        wk_q.accepted <= ok_q;
        wk_q.count    <= cnt_q;
        wk_q.rdy      <= (cnt_q >= thresh_i);
        wk_q.ibi_avg  <= '0;
        wk_q.mean_hr  <= '0;
        wk_q.sdnn     <= '0;
        wk_q.rmssd    <= '0;
      end
      ST_P0: begin
        prod_q <= mul_a * mul_b;
        nq_q   <= cnt_q * sq_q;
        nn_q   <= cnt_q * (cnt_q - 1'b1);
      end
      ST_P1: begin
        num_q  <= DivNW'(nq_q) - prod_q;
        prod_q <= mul_a * mul_b;
      end
      ST_DIVW: begin
        if (div_done) begin
          case (k_q)
            2'd0: wk_q.ibi_avg <= div_quo[IbiW-1:0];
            2'd1: wk_q.mean_hr <= (div_quo > DivNW'(HrSat)) ? HrSat : div_quo[HrW-1:0];
            2'd2: var_q <= div_quo;
            default: rdv_q <= div_quo;
          endcase
        end
      end
      ST_SQW: begin
        if (sq_done) begin
          if (k_q[0]) wk_q.rmssd <= sq_root[IbiW-1:0];
          else        wk_q.sdnn  <= sq_root[IbiW-1:0];
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) res_q <= wk_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### src/hrv_window_statistics.sv
// A rejected interval skips the window update. Statistics are computed only on a window
// of two or more samples, by four 48-step divides and two 24-step roots.
// The back end handles one interval at a time; a two-entry queue takes new intervals
// while the back end works, and a stalled result holds the back end until it is taken.
// Reset (async, low): window empty, sums zero, ready threshold 2, no result pending.
// Top level of the HRV window statistics block.
module hrv_window_statistics (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hws_pkg::CntW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hws_pkg::IbiW-1:0]  ibi_q4_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      accepted_o,
  output logic [hws_pkg::CntW-1:0]  sample_count_o,
  output logic                      ready_res_o,
  output logic [hws_pkg::IbiW-1:0]  mean_ibi_q4_o,
  output logic [hws_pkg::HrW-1:0]   mean_hr_q4_o,
  output logic [hws_pkg::IbiW-1:0]  sdnn_q4_o,
  output logic [hws_pkg::IbiW-1:0]  rmssd_q4_o
);
  import hws_pkg::*;

  logic [CntW-1:0] thresh_q;
  logic            q_full, q_push, q_pop, q_empty;
  hws_item_t       f_item, b_item;
  hws_res_t        res;

  // Ready threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshRst;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  hws_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ibi_q4_i   (ibi_q4_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (f_item)
  );

  hws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (b_item)
  );

  hws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_item_i    (b_item),
    .thresh_i    (thresh_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign accepted_o     = res.accepted;
  assign sample_count_o = res.count;
  assign ready_res_o    = res.rdy;
  assign mean_ibi_q4_o  = res.ibi_avg;
  assign mean_hr_q4_o   = res.mean_hr;
  assign sdnn_q4_o      = res.sdnn;
  assign rmssd_q4_o     = res.rmssd;

endmodule

### src/hws_checker.sv
// Port-level checks for the HRV window statistics block, bound to the top level.
module hws_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      accepted_o,
  input logic [hws_pkg::CntW-1:0]  sample_count_o,
  input logic [hws_pkg::IbiW-1:0]  mean_ibi_q4_o,
  input logic [hws_pkg::HrW-1:0]   mean_hr_q4_o,
  input logic [hws_pkg::IbiW-1:0]  sdnn_q4_o,
  input logic [hws_pkg::IbiW-1:0]  rmssd_q4_o
);
  import hws_pkg::*;

  // Stalled result holds its count
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_count_o))
    else $error("result changed while stalled");

  // Window never reports more than its depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o <= CntW'(WinDepth))
    else $error("sample count above window depth");

  // Statistics are zero below two samples
  a_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_count_o < CntW'(2) |->
      mean_ibi_q4_o == '0 && mean_hr_q4_o == '0 && sdnn_q4_o == '0 && rmssd_q4_o == '0)
    else $error("nonzero statistics on a short window");

  // A stored interval leaves at least one sample and a nonzero mean when two or more
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o && sample_count_o >= CntW'(2) |->
      mean_ibi_q4_o != '0 && mean_hr_q4_o != '0)
    else $error("zero mean with a populated window");

endmodule

bind hrv_window_statistics hws_checker u_hws_checker (.*);

### verif/tb_hrv_window_statistics.sv
// Testbench for the HRV window statistics block: directed and random intervals, scoreboard check.
module tb_hrv_window_statistics;
  import hws_pkg::*;

  // Expected result of one interval
  typedef struct {
    logic            accepted;
    logic [CntW-1:0] count;
    logic            rdy;
    logic [IbiW-1:0] ibi_avg;
    logic [HrW-1:0]  mean_hr;
    logic [IbiW-1:0] sdnn;
    logic [IbiW-1:0] rmssd;
  } stats_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CntW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [IbiW-1:0] ibi_q4_i;
  logic out_valid_o, out_ready_i;
  logic accepted_o, ready_res_o;
  logic [CntW-1:0] sample_count_o;
  logic [IbiW-1:0] mean_ibi_q4_o, sdnn_q4_o, rmssd_q4_o;
  logic [HrW-1:0] mean_hr_q4_o;

  hrv_window_statistics u_top (.*);

  // Predictor state
  logic [IbiW-1:0] ibi_ring [WinDepth];
  int unsigned     ring_wr;
  int unsigned     ring_cnt;
  longint unsigned sum_ibi, sum_sq, sum_ssd;
  logic [CntW-1:0] thresh;

  logic [IbiW-1:0] ibi_pending [$];
  stats_t          stats_expected [$];
  int              errors;
  int              in_gap, out_gap;
  longint          cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sqdiff(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Update the window with one interval and compute its statistics
  function automatic stats_t window_update(logic [IbiW-1:0] ibi);
    stats_t r;
    bit ok;
    int unsigned wi;
    longint unsigned n, s, hr;
    ok = (ibi != 0) && (ibi <= IbiMax);
    if (ok) begin
      wi = ring_wr;
      if (ring_cnt >= WinDepth) begin
        sum_ibi -= ibi_ring[wi];
        sum_sq  -= longint'(ibi_ring[wi]) * ibi_ring[wi];
        sum_ssd -= sqdiff(ibi_ring[(wi + 1) % WinDepth], ibi_ring[wi]);
        ring_cnt = WinDepth - 1;
      end
      if (ring_cnt >= 1) sum_ssd += sqdiff(ibi, ibi_ring[(wi + WinDepth - 1) % WinDepth]);
      ibi_ring[wi] = ibi;
      sum_ibi += ibi;
      sum_sq  += longint'(ibi) * ibi;
      ring_wr = (wi + 1) % WinDepth;
      ring_cnt++;
    end
    n = ring_cnt;
    s = sum_ibi;
    r.accepted = ok;
    r.count    = CntW'(n);
    r.rdy      = (n >= thresh);
    r.ibi_avg  = '0;
    r.mean_hr  = '0;
    r.sdnn     = '0;
    r.rmssd    = '0;
    if (n >= 2) begin
      r.ibi_avg = IbiW'(s / n);
      if (s != 0) begin
        hr = (longint'(HrNumer) * n) / s;
        r.mean_hr = (hr > HrSat) ? HrSat : HrW'(hr);
      end
      r.sdnn  = IbiW'(isqrt((n * sum_sq - s * s) / (n * (n - 1))));
      r.rmssd = IbiW'(isqrt(sum_ssd / (n - 1)));
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  // Random interval: mostly plausible with varied spread, some rejected
  function automatic logic [IbiW-1:0] random_ibi();
    case ($urandom_range(0, 9))
      0:       return IbiW'($urandom_range(160001, 262143));
      1:       return '0;
      2:       return IbiW'($urandom_range(1, 160000));
      3:       return IbiW'($urandom_range(150000, 160000));
      default: return IbiW'($urandom_range(8000, 20000));
    endcase
  endfunction

  // Driver: feeds intervals and predicts at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ibi_q4_i   <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        stats_expected.push_back(window_update(ibi_q4_i));
        void'(ibi_pending.pop_front());
        in_gap <= pick_gap();
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0 && !(in_valid_i && in_ready_o)) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!(in_valid_i && in_ready_o) && ibi_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          ibi_q4_i   <= ibi_pending[0];
        end else if (in_valid_i && in_ready_o && ibi_pending.size() > 0 && in_gap == 0
                     && $urandom_range(0, 1)) begin
          in_valid_i <= 1'b1;
          ibi_q4_i   <= ibi_pending[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (stats_expected.size() == 0) begin
          $error("result with no expectation");
          errors++;
        end else begin
          e = stats_expected.pop_front();
          if (accepted_o !== e.accepted) begin
            $error("accepted exp %0d got %0d", e.accepted, accepted_o); errors++;
          end
          if (sample_count_o !== e.count) begin
            $error("sample_count exp %0d got %0d", e.count, sample_count_o); errors++;
          end
          if (ready_res_o !== e.rdy) begin
            $error("ready_res exp %0d got %0d", e.rdy, ready_res_o); errors++;
          end
          if (mean_ibi_q4_o !== e.ibi_avg) begin
            $error("mean_ibi_q4 exp %0d got %0d", e.ibi_avg, mean_ibi_q4_o); errors++;
          end
          if (mean_hr_q4_o !== e.mean_hr) begin
            $error("mean_hr_q4 exp %0d got %0d", e.mean_hr, mean_hr_q4_o); errors++;
          end
          if (sdnn_q4_o !== e.sdnn) begin
            $error("sdnn_q4 exp %0d got %0d", e.sdnn, sdnn_q4_o); errors++;
          end
          if (rmssd_q4_o !== e.rmssd) begin
            $error("rmssd_q4 exp %0d got %0d", e.rmssd, rmssd_q4_o); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) out_gap <= pick_gap();
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 10000000) begin
      $display("FAIL hrv_window_statistics");
      $finish;
    end
  end

  task automatic drain();
    while (ibi_pending.size() > 0 || in_valid_i || stats_expected.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [CntW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    thresh = v;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    ring_wr = 0;
    ring_cnt = 0;
    sum_ibi = 0;
    sum_sq = 0;
    sum_ssd = 0;
    thresh = ThreshRst;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejections on an empty window, one sample, extremes, all-ones
    ibi_pending.push_back('0);
    ibi_pending.push_back(18'h3FFFF);
    ibi_pending.push_back(18'd160001);
    ibi_pending.push_back(18'd1);
    ibi_pending.push_back('0);
    ibi_pending.push_back(18'd160000);
    ibi_pending.push_back(18'd1);
    ibi_pending.push_back(18'd160000);
    ibi_pending.push_back(18'h2AAAA);
    ibi_pending.push_back(18'h15555);
    ibi_pending.push_back(18'd16000);
    ibi_pending.push_back(18'd16000);
    drain();

    // Threshold extremes, a random value and the reset value, each with a burst that fills and wraps the window
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(7'd0);
        1: write_threshold(7'd64);
        2: write_threshold(7'd127);
        3: write_threshold(CntW'($urandom_range(1, 63)));
        default: write_threshold(7'd2);
      endcase
      for (int k = 0; k < 328; k++) ibi_pending.push_back(random_ibi());
      drain();
    end
    if (errors == 0) begin
      $display("PASS hrv_window_statistics");
    end else begin
      $display("FAIL hrv_window_statistics");
    end
    $finish;
  end

endmodule

### files.f
src/hws_pkg.sv
src/hws_ram.sv
src/hws_front.sv
src/hws_queue.sv
src/hws_div.sv
src/hws_sqrt.sv
src/hws_back.sv
src/hrv_window_statistics.sv
src/hws_checker.sv
verif/tb_hrv_window_statistics.sv
